>>> hw/rtl/rainbow_gradient_digit_colors_top_defines.svh
// assertion macros used by the rainbow digit color back end
`ifndef RAINBOW_GRADIENT_DIGIT_COLORS_TOP_DEFINES_SVH
`define RAINBOW_GRADIENT_DIGIT_COLORS_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RGDC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgdc assertion failed");

// next-cycle implication, disabled during reset
`define RGDC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgdc assertion failed");

`endif

>>> hw/rtl/rgdc_pkg.sv
// types, constants and lookup functions for the rainbow digit color block
package rgdc_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_SATURATION = 2'd0;
   localparam logic [1:0] CSR_BRIGHTNESS = 2'd1;
   localparam logic [1:0] CSR_SPACING    = 2'd2;

   localparam logic [7:0] SATURATION_RESET = 8'd255;
   localparam logic [7:0] BRIGHTNESS_RESET = 8'd255;
   localparam logic [7:0] SPACING_RESET    = 8'd9;

   localparam int ITEM_QUEUE_DEPTH   = 2;
   localparam int RESULT_QUEUE_DEPTH = 8;

   localparam logic [3:0] DIGIT_MAX    = 4'd9;
   localparam logic [4:0] LED_LAST     = 5'd28;
   localparam logic [7:0] REGION_WIDTH = 8'd43;

   typedef struct packed {
      logic [3:0] digit;
      logic       show_point;
      logic [7:0] step;
   } req_type;

   typedef struct packed {
      logic [4:0] led_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] saturation;
      logic [7:0] brightness_value;
      logic [7:0] hue_spacing;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic       bad_digit;
      logic [6:0] seg_mask;
      logic       show_point;
      logic [7:0] step;
   } item_type;

   // segment pattern, bit 0 is segment a
   function automatic logic [6:0] seg_mask_of(input logic [3:0] digit);
      logic [6:0] m;
      unique case (digit)
         4'd0:    m = 7'b0111111;
         4'd1:    m = 7'b0000110;
         4'd2:    m = 7'b1011011;
         4'd3:    m = 7'b1001111;
         4'd4:    m = 7'b1100110;
         4'd5:    m = 7'b1101101;
         4'd6:    m = 7'b1111101;
         4'd7:    m = 7'b0000111;
         4'd8:    m = 7'b1111111;
         4'd9:    m = 7'b1101111;
         default: m = 7'b0000000;
      endcase
      return m;
   endfunction

   // led position for the k-th result; segments f and g swap places on the strip
   function automatic logic [4:0] led_of(input logic [4:0] k);
      logic [4:0] base;
      unique case (k[4:2])
         3'd5:    base = 5'd24;
         3'd6:    base = 5'd20;
         default: base = {k[4:2], 2'b00};
      endcase
      return base | {3'b000, k[1:0]};
   endfunction

endpackage

>>> hw/rtl/rgdc_fifo.sv
// small flip-flop queue with head-of-queue read and fill count
module rgdc_fifo
   import rgdc_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             head_data,
   output logic                         empty,
   output logic                         full,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(DEPTH));
   assign count     = count_ff;
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/rgdc_front.sv
// front end: accepts digit transactions, classifies them and queues them
module rgdc_front
   import rgdc_pkg::*;
#(
   parameter int QUEUE_DEPTH = ITEM_QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_push,
   input  req_type  req_data,
   output logic     req_full,
   output logic     item_valid,
   output item_type item,
   input  logic     item_pop
);

   item_type                         classified;
   logic                             q_empty;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
   logic [$bits(item_type)-1:0]      q_head;

   // decode digit into segment pattern, flag out-of-range digits
   always_comb begin
      classified.bad_digit  = (req_data.digit > DIGIT_MAX);
      classified.seg_mask   = seg_mask_of(req_data.digit);
      classified.show_point = req_data.show_point;
      classified.step       = req_data.step;
   end

   rgdc_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (classified),
      .pop       (item_pop),
      .head_data (q_head),
      .empty     (q_empty),
      .full      (req_full),
      .count     (q_count)
   );

   assign item       = item_type'(q_head);
   assign item_valid = !q_empty && (q_count != '0);

endmodule

>>> hw/rtl/rgdc_back.sv
// back end: walks the leds of each item and converts hue to rgb in three stages
module rgdc_back
   import rgdc_pkg::*;
#(
   parameter int RESULT_DEPTH = RESULT_QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

`include "rainbow_gradient_digit_colors_top_defines.svh"

   localparam int CW = $clog2(RESULT_DEPTH + 1);
   localparam int SW = CW + 1;

   // sequencer
   logic [4:0]  k_ff, k_in;
   logic        issue, cur_last, cur_lit;
   logic [4:0]  cur_led;
   logic [12:0] hue_prod;
   logic [7:0]  hue0;

   // stage 1
   logic        s1_valid_ff;
   logic [7:0]  s1_hue_ff;
   logic [4:0]  s1_led_ff;
   logic        s1_lit_ff, s1_status_ff, s1_last_ff;

   // stage 2
   logic [2:0]  region;
   logic [7:0]  region_base;
   logic [5:0]  region_off;
   logic [7:0]  rem;
   logic [15:0] sr_prod, st_prod, p_prod;
   logic        s2_valid_ff;
   logic [2:0]  s2_region_ff;
   logic [7:0]  s2_sr_ff, s2_st_ff, s2_p_ff;
   logic [4:0]  s2_led_ff;
   logic        s2_lit_ff, s2_status_ff, s2_last_ff;

   // stage 3
   logic [15:0] q_prod, t_prod;
   logic [7:0]  q_val, t_val, v_val, p_val;
   rsp_type     s3_in;
   logic        s3_valid_ff;
   rsp_type     s3_ff;

   // result queue
   logic [CW-1:0]            res_count;
   logic                     res_full;
   logic [$bits(rsp_type)-1:0] res_head;
   logic [SW-1:0]            in_flight;
   logic                     credit_ok;

   // issue only when the result queue has room for everything in flight
   assign in_flight = SW'(s1_valid_ff) + SW'(s2_valid_ff) + SW'(s3_valid_ff);
   assign credit_ok = (SW'(res_count) + in_flight) < SW'(RESULT_DEPTH);
   assign issue     = item_valid && credit_ok;

   // led walk over the current item
   always_comb begin
      cur_last = item.bad_digit || (k_ff == LED_LAST);
      cur_led  = item.bad_digit ? 5'd0 : led_of(k_ff);
      if (item.bad_digit) begin
         cur_lit = 1'b0;
      end else if (k_ff == LED_LAST) begin
         cur_lit = item.show_point;
      end else begin
         cur_lit = item.seg_mask[k_ff[4:2]];
      end
      item_pop = issue && cur_last;
      k_in     = k_ff;
      if (issue) begin
         k_in = cur_last ? 5'd0 : k_ff + 5'd1;
      end
      hue_prod = 13'(cur_led) * 13'(cfg.hue_spacing);
      hue0     = item.step + hue_prod[7:0];
   end

   // region and remainder from hue
   always_comb begin
      if (s1_hue_ff < REGION_WIDTH) begin
         region = 3'd0;
      end else if (s1_hue_ff < 8'(2 * REGION_WIDTH)) begin
         region = 3'd1;
      end else if (s1_hue_ff < 8'(3 * REGION_WIDTH)) begin
         region = 3'd2;
      end else if (s1_hue_ff < 8'(4 * REGION_WIDTH)) begin
         region = 3'd3;
      end else if (s1_hue_ff < 8'(5 * REGION_WIDTH)) begin
         region = 3'd4;
      end else begin
         region = 3'd5;
      end
      region_base = 8'(region * REGION_WIDTH);
      region_off  = 6'(s1_hue_ff - region_base);
      rem         = 8'(region_off) * 8'd6;
      sr_prod     = 16'(cfg.saturation) * 16'(rem);
      st_prod     = 16'(cfg.saturation) * 16'(8'd255 - rem);
      p_prod      = 16'(cfg.brightness_value) * 16'(8'd255 - cfg.saturation);
   end

   // final products and channel selection
   always_comb begin
      v_val  = cfg.brightness_value;
      p_val  = s2_p_ff;
      q_prod = 16'(v_val) * 16'(8'd255 - s2_sr_ff);
      t_prod = 16'(v_val) * 16'(8'd255 - s2_st_ff);
      q_val  = q_prod[15:8];
      t_val  = t_prod[15:8];
      s3_in.led_index = s2_led_ff;
      s3_in.status    = s2_status_ff;
      s3_in.last      = s2_last_ff;
      if (!s2_lit_ff) begin
         s3_in.red   = 8'd0;
         s3_in.green = 8'd0;
         s3_in.blue  = 8'd0;
      end else if (cfg.saturation == 8'd0) begin
         s3_in.red   = v_val;
         s3_in.green = v_val;
         s3_in.blue  = v_val;
      end else begin
         case (s2_region_ff)
            3'd0: begin
               s3_in.red = v_val; s3_in.green = t_val; s3_in.blue = p_val;
            end
            3'd1: begin
               s3_in.red = q_val; s3_in.green = v_val; s3_in.blue = p_val;
            end
            3'd2: begin
               s3_in.red = p_val; s3_in.green = v_val; s3_in.blue = t_val;
            end
            3'd3: begin
               s3_in.red = p_val; s3_in.green = q_val; s3_in.blue = v_val;
            end
            3'd4: begin
               s3_in.red = t_val; s3_in.green = p_val; s3_in.blue = v_val;
            end
            default: begin
               s3_in.red = v_val; s3_in.green = p_val; s3_in.blue = q_val;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff        <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         k_ff        <= k_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      s1_hue_ff    <= hue0;
      s1_led_ff    <= cur_led;
      s1_lit_ff    <= cur_lit;
      s1_status_ff <= item.bad_digit;
      s1_last_ff   <= cur_last;
      s2_region_ff <= region;
      s2_sr_ff     <= sr_prod[15:8];
      s2_st_ff     <= st_prod[15:8];
      s2_p_ff      <= p_prod[15:8];
      s2_led_ff    <= s1_led_ff;
      s2_lit_ff    <= s1_lit_ff;
      s2_status_ff <= s1_status_ff;
      s2_last_ff   <= s1_last_ff;
      s3_ff        <= s3_in;
   end

   rgdc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_valid_ff),
      .push_data (s3_ff),
      .pop       (rsp_pop),
      .head_data (res_head),
      .empty     (rsp_empty),
      .full      (res_full),
      .count     (res_count)
   );

   assign rsp_data = rsp_type'(res_head);

   `RGDC_ASSERT_NEXT(a_last_rewinds, clock, reset, issue && cur_last, k_ff == 5'd0)
   `RGDC_ASSERT_IMPLIES(a_no_overflow, clock, reset, s3_valid_ff, !res_full)
   `RGDC_ASSERT_IMPLIES(a_walk_range, clock, reset, 1'b1, k_ff <= LED_LAST)
   `RGDC_ASSERT_IMPLIES(a_bad_digit_first, clock, reset, item_valid && item.bad_digit, k_ff == 5'd0)

endmodule

>>> hw/rtl/rainbow_gradient_digit_colors_top.sv
// a digit's first led color passes the item queue, the hue pipeline and the result queue after it is accepted
// a valid digit gives 29 led colors, one per cycle from the led walk sequencer while the result queue has room
// an out-of-range digit gives a single black error result
// a two-entry item queue lets the next digit be accepted while the current one is walked
// reset is synchronous and active high: queues and pipeline empty, registers to 255/255/9
module rainbow_gradient_digit_colors_top
   import rgdc_pkg::*;
#(
   parameter int QUEUE_DEPTH  = ITEM_QUEUE_DEPTH,
   parameter int RESULT_DEPTH = RESULT_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  req_type    req_data,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     item_valid, item_pop;
   item_type item;

   // configuration registers, unknown index ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SATURATION: cfg_in.saturation       = csr_data;
            CSR_BRIGHTNESS: cfg_in.brightness_value = csr_data;
            CSR_SPACING:    cfg_in.hue_spacing      = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.saturation       <= SATURATION_RESET;
         cfg_ff.brightness_value <= BRIGHTNESS_RESET;
         cfg_ff.hue_spacing      <= SPACING_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rgdc_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   rgdc_back #(
      .RESULT_DEPTH (RESULT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for the rainbow gradient seven-segment digit color block
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rgdc_pkg::*;

   // index with no register behind it, writes there must be ignored
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_DIGIT = 1'b1;

   // segment patterns per digit, bit 0 is segment a
   localparam logic [6:0] SEGMENT_PATTERNS [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };
   // first strip position of segments a..g, f and g sit swapped on the strip
   localparam int SEGMENT_FIRST_LED [7] = '{0, 4, 8, 12, 16, 24, 20};

   localparam int ITEMS_PER_PHASE = 55;
   localparam int RANDOM_PHASES   = 6;
   localparam int IDLE_SETTLE     = 12;
   localparam int LONG_HOLD       = 300;
   localparam int MAX_REPORTS     = 10;

   typedef enum {POP_ALWAYS, POP_HALF, POP_RARE, POP_MOST} pop_style_type;

   // expected led colors and the color predictor
   class digit_color_board;
      rsp_type    expected_colors[$];
      logic [7:0] saturation = SATURATION_RESET;
      logic [7:0] brightness = BRIGHTNESS_RESET;
      logic [7:0] hue_spacing = SPACING_RESET;
      int         failures;
      int         colors_checked;
      int         bad_digits;

      function void set_register(logic [1:0] index, logic [7:0] data);
         case (index)
            CSR_SATURATION: saturation = data;
            CSR_BRIGHTNESS: brightness = data;
            CSR_SPACING:    hue_spacing = data;
            default:        ;
         endcase
      endfunction

      function int outstanding();
         return expected_colors.size();
      endfunction

      // 8-bit integer hsv to rgb with six regions, 43 hues wide but the last only 41
      function rsp_type led_color(int led, logic lit, logic [7:0] step);
         rsp_type c;
         int hue, s, v, region, rem, p, q, t, r, g, b;
         c = '0;
         c.led_index = 5'(led);
         c.status = STATUS_OK;
         if (!lit) return c;
         hue = (int'(step) + led * int'(hue_spacing)) % 256;
         s = saturation;
         v = brightness;
         if (s == 0) begin
            r = v; g = v; b = v;
         end else begin
            region = hue / 43;
            rem = (hue - region * 43) * 6;
            p = (v * (255 - s)) >> 8;
            q = (v * (255 - ((s * rem) >> 8))) >> 8;
            t = (v * (255 - ((s * (255 - rem)) >> 8))) >> 8;
            case (region)
               0:       begin r = v; g = t; b = p; end
               1:       begin r = q; g = v; b = p; end
               2:       begin r = p; g = v; b = t; end
               3:       begin r = p; g = q; b = v; end
               4:       begin r = t; g = p; b = v; end
               default: begin r = v; g = p; b = q; end
            endcase
         end
         c.red = 8'(r);
         c.green = 8'(g);
         c.blue = 8'(b);
         return c;
      endfunction

      // work out every color that an accepted digit transaction causes
      function void note_digit(req_type item);
         rsp_type    c;
         logic [6:0] segs;
         c = '0;
         if (item.digit > DIGIT_MAX) begin
            c.status = STATUS_BAD_DIGIT;
            c.last = 1'b1;
            expected_colors.push_back(c);
            bad_digits++;
            return;
         end
         segs = SEGMENT_PATTERNS[item.digit];
         for (int seg = 0; seg < 7; seg++)
            for (int i = 0; i < 4; i++)
               expected_colors.push_back(
                  led_color(SEGMENT_FIRST_LED[seg] + i, segs[seg], item.step));
         c = led_color(int'(LED_LAST), item.show_point, item.step);
         c.last = 1'b1;
         expected_colors.push_back(c);
      endfunction

      function void report(string what);
         failures++;
         if (failures <= MAX_REPORTS) $display("[%0t] %s", $realtime, what);
      endfunction

      // compare one accepted color against the oldest expectation
      function void check_color(rsp_type got);
         rsp_type want;
         if (expected_colors.size() == 0) begin
            report($sformatf("unexpected color led=%0d rgb=%0d,%0d,%0d status=%0d last=%0d",
                             got.led_index, got.red, got.green, got.blue,
                             got.status, got.last));
            return;
         end
         want = expected_colors.pop_front();
         colors_checked++;
         if (got.led_index !== want.led_index || got.red !== want.red ||
             got.green !== want.green || got.blue !== want.blue ||
             got.status !== want.status || got.last !== want.last)
            report($sformatf({"color mismatch: expected led=%0d rgb=%0d,%0d,%0d ",
                              "status=%0d last=%0d, got led=%0d rgb=%0d,%0d,%0d ",
                              "status=%0d last=%0d"},
                             want.led_index, want.red, want.green, want.blue,
                             want.status, want.last, got.led_index, got.red,
                             got.green, got.blue, got.status, got.last));
      endfunction

      function void close_out();
         if (expected_colors.size() != 0)
            report($sformatf("%0d expected colors never arrived", expected_colors.size()));
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   req_type    req_data = '0;
   logic       req_full;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write = 1'b0;
   logic [1:0] csr_index = CSR_SATURATION;
   logic [7:0] csr_data = '0;

   digit_color_board board = new();
   bit long_hold_req;
   int items_sent;
   int settings_loaded;
   int full_stalls;

   rainbow_gradient_digit_colors_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // count edges where the sender was held back by a full input queue
   always @(posedge clock) begin
      if (!reset && req_push && req_full) full_stalls++;
   end

   // result side: check each popped color, stall on a pattern of its own
   initial begin
      pop_style_type style;
      int style_left;
      int hold_left;
      style = POP_ALWAYS;
      style_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) board.check_color(rsp_data);
         if (hold_left == 0 && long_hold_req) begin
            hold_left = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (style_left == 0) begin
            style = pop_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(20, 120);
         end
         style_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (style)
               POP_ALWAYS: rsp_pop <= 1'b1;
               POP_HALF:   rsp_pop <= $urandom_range(0, 1);
               POP_RARE:   rsp_pop <= ($urandom_range(0, 3) == 0);
               default:    rsp_pop <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // offer one digit transaction and hold it until accepted
   task automatic offer_digit(input req_type item);
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      board.note_digit(item);
      items_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      req_push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // stop sending and let every expected color come back
   task automatic wait_idle();
      req_push <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // write all three color registers plus the unused index
   task automatic load_color_regs(input logic [7:0] sat, input logic [7:0] bright,
                                  input logic [7:0] spacing);
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      csr_write <= 1'b1;
      csr_index <= CSR_SATURATION;
      csr_data <= sat;
      @(posedge clock);
      board.set_register(CSR_SATURATION, sat);
      csr_index <= CSR_BRIGHTNESS;
      csr_data <= bright;
      @(posedge clock);
      board.set_register(CSR_BRIGHTNESS, bright);
      csr_index <= CSR_SPACING;
      csr_data <= spacing;
      @(posedge clock);
      board.set_register(CSR_SPACING, spacing);
      csr_index <= CSR_UNUSED;
      csr_data <= junk;
      @(posedge clock);
      board.set_register(CSR_UNUSED, junk);
      csr_write <= 1'b0;
      settings_loaded++;
   endtask

   function automatic req_type make_digit(int digit, int point, int step);
      req_type item;
      item.digit = 4'(digit);
      item.show_point = 1'(point);
      item.step = 8'(step);
      return item;
   endfunction

   // mostly valid digits, some out of range
   function automatic req_type random_digit();
      int digit;
      digit = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 9) : $urandom_range(10, 15);
      return make_digit(digit, $urandom_range(0, 1), $urandom_range(0, 255));
   endfunction

   // run limit
   initial begin
      #3_000_000;
      $display("** rainbow_gradient_digit_colors_top: FAILED **");
      $finish;
   end

   // stimulus
   initial begin
      int directed_steps[10];
      int sent;
      int burst_len;
      int gap;
      bit drained;
      logic [7:0] sat, bright, spacing;
      directed_steps = '{0, 255, 42, 43, 85, 86, 128, 170, 213, 254};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every digit at reset settings, region edges and hue wrap, bad digits
      for (int d = 0; d < 10; d++) offer_digit(make_digit(d, d % 2, directed_steps[d]));
      offer_digit(make_digit(10, 1, 255));
      offer_digit(make_digit(15, 0, 0));
      wait_idle();

      // grey with widest spacing
      load_color_regs(8'd0, 8'd255, 8'd255);
      offer_digit(make_digit(8, 1, 200));
      offer_digit(make_digit(15, 1, 7));
      wait_idle();

      // full saturation, zero brightness, no spacing
      load_color_regs(8'd255, 8'd0, 8'd0);
      offer_digit(make_digit(8, 1, 100));
      wait_idle();

      // smallest nonzero settings
      load_color_regs(8'd1, 8'd1, 8'd1);
      offer_digit(make_digit(8, 1, 255));
      wait_idle();

      // largest settings
      load_color_regs(8'd255, 8'd255, 8'd255);
      offer_digit(make_digit(8, 1, 1));
      wait_idle();

      // random phases, each under its own register setting
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       begin sat = SATURATION_RESET; bright = BRIGHTNESS_RESET;
                           spacing = SPACING_RESET; end
            1:       begin sat = 8'd0; bright = 8'($urandom_range(0, 255));
                           spacing = 8'($urandom_range(0, 255)); end
            3:       begin sat = 8'd255; bright = 8'd255; spacing = 8'd255; end
            4:       begin sat = 8'($urandom_range(0, 255)); bright = 8'd255;
                           spacing = 8'd0; end
            5:       begin sat = 8'd1; bright = 8'($urandom_range(0, 255));
                           spacing = 8'($urandom_range(0, 255)); end
            default: begin sat = 8'($urandom_range(0, 255));
                           bright = 8'($urandom_range(0, 255));
                           spacing = 8'($urandom_range(0, 255)); end
         endcase
         wait_idle();
         load_color_regs(sat, bright, spacing);

         // hold the result side off while the sender keeps pushing
         if (ph == 1) begin
            long_hold_req = 1'b1;
            for (int k = 0; k < 12; k++) offer_digit(random_digit());
         end

         sent = 0;
         drained = 1'b0;
         while (sent < ITEMS_PER_PHASE) begin
            burst_len = $urandom_range(1, 8);
            for (int k = 0; k < burst_len; k++) offer_digit(random_digit());
            sent += burst_len;
            // sender waits once for every outstanding color mid phase
            if (ph == 2 && !drained && sent >= ITEMS_PER_PHASE / 2) begin
               wait_idle();
               drained = 1'b1;
            end else begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               if (gap > 0) pause_sender(gap);
            end
         end
      end

      wait_idle();
      board.close_out();
      $display("run covered %0d digit transactions (%0d out of range), %0d colors checked",
               items_sent, board.bad_digits, board.colors_checked);
      $display("across %0d register settings, with %0d cycles of input back-pressure",
               settings_loaded, full_stalls);
      if (board.failures == 0)
         $display("** rainbow_gradient_digit_colors_top: PASSED **");
      else
         $display("** rainbow_gradient_digit_colors_top: FAILED **");
      $finish;
   end

endmodule
